>>> rtl/rau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_CMP = 3'd4
    } op_t;

    localparam int unsigned REQ_TYPE_W = 3;
    localparam int unsigned RES_NUM_W  = 33;
    localparam int unsigned RES_DEN_W  = 31;
    localparam int unsigned CMP_W      = 2;

    localparam logic [CMP_W-1:0] CMP_LT = 2'b11;
    localparam logic [CMP_W-1:0] CMP_EQ = 2'b00;
    localparam logic [CMP_W-1:0] CMP_GT = 2'b01;

    typedef struct packed {
        logic load;
        logic prod;
        logic sum;
        logic gcd_step;
        logic div_start;
        logic finish;
    } rau_cmd_t;

    typedef struct packed {
        logic gcd_done;
        logic div_done;
        logic short_path;
    } rau_sts_t;

endpackage
`default_nettype wire

>>> rtl/rau_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rau_req_if #(
    parameter int OPERAND_WIDTH = 16
);
    logic                            valid;
    logic                            ready;
    logic [rau_pkg::REQ_TYPE_W-1:0]  req_type;
    logic signed [OPERAND_WIDTH-1:0] a_num;
    logic signed [OPERAND_WIDTH-1:0] a_den;
    logic signed [OPERAND_WIDTH-1:0] b_num;
    logic signed [OPERAND_WIDTH-1:0] b_den;

    modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
    modport sink (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_res_if #(
    parameter int OPERAND_WIDTH = 16
);
    logic                                 valid;
    logic                                 ready;
    logic signed [2*OPERAND_WIDTH:0]      res_num;
    logic [2*OPERAND_WIDTH-2:0]           res_den;
    logic signed [rau_pkg::CMP_W-1:0]     cmp_out;
    logic                                 status;

    modport source (output valid, res_num, res_den, cmp_out, status, input ready);
    modport sink (input valid, res_num, res_den, cmp_out, status, output ready);
endinterface
`default_nettype wire

>>> rtl/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | words
// req     | in  | req_type, a_num, a_den, b_num, b_den
// res     | out | res_num, res_den, cmp_out, status
//
// One word in flight. Compare, unused op codes and zero denominators skip the
// gcd and divide steps and go straight to the finish state.
// Arithmetic ops run binary gcd steps, then two shift-subtract divides that
// reduce the numerator and the denominator by the gcd.
// Reset clears only control. Input is taken only when idle; a held result
// stalls the next word in its finish state until the held one is taken.
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = 16
) (
    input  wire     clk,
    input  wire     rst_n,
    rau_req_if.sink req,
    rau_res_if.source res
);
    import rau_pkg::*;

    rau_cmd_t cmd;
    rau_sts_t sts;

    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    rau_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .clk      (clk),
        .cmd      (cmd),
        .sts      (sts),
        .req_type (req.req_type),
        .a_num    (req.a_num),
        .a_den    (req.a_den),
        .b_num    (req.b_num),
        .b_den    (req.b_den),
        .res_num  (res.res_num),
        .res_den  (res.res_den),
        .cmp_out  (res.cmp_out),
        .status   (res.status)
    );

endmodule
`default_nettype wire

>>> rtl/rau_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module rau_datapath #(
    parameter int OPERAND_WIDTH = 16
) (
    input  wire                                  clk,
    input  wire rau_pkg::rau_cmd_t               cmd,
    output rau_pkg::rau_sts_t                    sts,
    input  wire [rau_pkg::REQ_TYPE_W-1:0]        req_type,
    input  wire [OPERAND_WIDTH-1:0]              a_num,
    input  wire [OPERAND_WIDTH-1:0]              a_den,
    input  wire [OPERAND_WIDTH-1:0]              b_num,
    input  wire [OPERAND_WIDTH-1:0]              b_den,
    output logic [2*OPERAND_WIDTH:0]             res_num,
    output logic [2*OPERAND_WIDTH-2:0]           res_den,
    output logic [rau_pkg::CMP_W-1:0]            cmp_out,
    output logic                                 status
);
    import rau_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;
    localparam int MW = PW + 1;
    localparam int CW = $clog2(MW + 1);

    logic [REQ_TYPE_W-1:0] op_reg;
    logic [W-1:0] an_m, ad_m, bn_m, bd_m;
    logic an_s, ad_s, bn_s, bd_s;
    logic [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic an_s_reg, ad_s_reg, bn_s_reg, bd_s_reg;
    logic [PW-1:0] p1_reg, p2_reg, p3_reg;
    logic p1_s_reg, p2_s_reg, p3_s_reg;
    logic [MW-1:0] num_reg, den_reg;
    logic num_s_reg, den_s_reg;
    logic [MW-1:0] gx_reg, gy_reg;
    logic [CW-1:0] gk_reg;
    logic [MW-1:0] qd_reg, rem_reg, quo_reg;
    logic [CW-1:0] cnt_reg;
    logic div_sel_reg, div_busy_reg, div_done_reg;
    logic [MW-1:0] q_num_reg;

    logic [MW-1:0] sum_m;
    logic sum_s;
    logic [MW-1:0] p1e, p2e;
    logic p2n;

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        mag_of = v[W-1] ? (~v + 1'b1) : v;
    endfunction

    assign an_m = mag_of(a_num);
    assign ad_m = mag_of(a_den);
    assign bn_m = mag_of(b_num);
    assign bd_m = mag_of(b_den);
    assign an_s = a_num[W-1];
    assign ad_s = a_den[W-1];
    assign bn_s = b_num[W-1];
    assign bd_s = b_den[W-1];

    assign p1e = {1'b0, p1_reg};
    assign p2e = {1'b0, p2_reg};
    assign p2n = (op_reg == OP_SUB) ? ((p2_reg != '0) & ~p2_s_reg) : p2_s_reg;

    always_comb
    begin
        if (p1_s_reg == p2n)
        begin
            sum_m = p1e + p2e;
            sum_s = p1_s_reg;
        end
        else if (p1e >= p2e)
        begin
            sum_m = p1e - p2e;
            sum_s = p1_s_reg;
        end
        else
        begin
            sum_m = p2e - p1e;
            sum_s = p2n;
        end
        if (sum_m == '0)
            sum_s = 1'b0;
    end

    logic [MW-1:0] rem_sh, rem_try;
    assign rem_sh  = {rem_reg[MW-2:0], qd_reg[MW-1]};
    assign rem_try = rem_sh - gy_reg;

    logic cmp_neg1, cmp_neg2;
    assign cmp_neg1 = p1_s_reg & (p1_reg != '0);
    assign cmp_neg2 = p2_s_reg & (p2_reg != '0);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= req_type;
            an_reg   <= an_m;
            ad_reg   <= ad_m;
            bn_reg   <= bn_m;
            bd_reg   <= bd_m;
            an_s_reg <= an_s;
            ad_s_reg <= ad_s;
            bn_s_reg <= bn_s;
            bd_s_reg <= bd_s;
            div_busy_reg <= 1'b0;
            div_done_reg <= 1'b0;
        end
        if (cmd.prod)
        begin
            if (op_reg == OP_MUL)
            begin
                p1_reg   <= an_reg * bn_reg;
                p1_s_reg <= an_s_reg ^ bn_s_reg;
            end
            else
            begin
                p1_reg   <= an_reg * bd_reg;
                p1_s_reg <= an_s_reg ^ bd_s_reg;
            end
            p2_reg   <= ad_reg * bn_reg;
            p2_s_reg <= ad_s_reg ^ bn_s_reg;
            if (op_reg == OP_DIV)
            begin
                p3_reg   <= ad_reg * bn_reg;
                p3_s_reg <= ad_s_reg ^ bn_s_reg;
            end
            else
            begin
                p3_reg   <= ad_reg * bd_reg;
                p3_s_reg <= ad_s_reg ^ bd_s_reg;
            end
        end
        if (cmd.sum)
        begin
            if (op_reg == OP_ADD || op_reg == OP_SUB)
            begin
                num_reg   <= sum_m;
                num_s_reg <= sum_s;
                gx_reg    <= sum_m;
            end
            else
            begin
                num_reg   <= p1e;
                num_s_reg <= p1_s_reg & (p1_reg != '0);
                gx_reg    <= p1e;
            end
            den_reg   <= {1'b0, p3_reg};
            den_s_reg <= p3_s_reg;
            gy_reg    <= {1'b0, p3_reg};
            gk_reg    <= '0;
        end
        if (cmd.gcd_step)
        begin
            // binary gcd: strip common twos, reduce odd pairs, then put the twos back
            if (gx_reg == '0)
            begin
                gy_reg <= {gy_reg[MW-2:0], 1'b0};
                gk_reg <= gk_reg - 1'b1;
            end
            else if (!gx_reg[0] && !gy_reg[0])
            begin
                gx_reg <= gx_reg >> 1;
                gy_reg <= gy_reg >> 1;
                gk_reg <= gk_reg + 1'b1;
            end
            else if (!gx_reg[0])
                gx_reg <= gx_reg >> 1;
            else if (!gy_reg[0])
                gy_reg <= gy_reg >> 1;
            else if (gx_reg >= gy_reg)
                gx_reg <= (gx_reg - gy_reg) >> 1;
            else
            begin
                gx_reg <= (gy_reg - gx_reg) >> 1;
                gy_reg <= gx_reg;
            end
        end
        if (cmd.div_start)
        begin
            qd_reg       <= num_reg;
            rem_reg      <= '0;
            quo_reg      <= '0;
            cnt_reg      <= CW'(MW);
            div_sel_reg  <= 1'b0;
            div_busy_reg <= 1'b1;
            div_done_reg <= 1'b0;
        end
        else if (div_busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                if (!rem_try[MW-1] && rem_sh >= gy_reg)
                begin
                    rem_reg <= rem_try;
                    quo_reg <= {quo_reg[MW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[MW-2:0], 1'b0};
                end
                qd_reg  <= {qd_reg[MW-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
            end
            else if (!div_sel_reg)
            begin
                q_num_reg   <= quo_reg;
                qd_reg      <= den_reg;
                rem_reg     <= '0;
                quo_reg     <= '0;
                cnt_reg     <= CW'(MW);
                div_sel_reg <= 1'b1;
            end
            else
            begin
                div_busy_reg <= 1'b0;
                div_done_reg <= 1'b1;
            end
        end
        if (cmd.finish)
        begin
            res_num <= '0;
            res_den <= '0;
            cmp_out <= CMP_EQ;
            status  <= 1'b0;
            if (op_reg == OP_CMP)
            begin
                if (cmp_neg1 != cmp_neg2)
                    cmp_out <= cmp_neg1 ? CMP_LT : CMP_GT;
                else if (p1_reg == p2_reg)
                    cmp_out <= CMP_EQ;
                else if (cmp_neg1)
                    cmp_out <= (p1_reg > p2_reg) ? CMP_LT : CMP_GT;
                else
                    cmp_out <= (p1_reg > p2_reg) ? CMP_GT : CMP_LT;
            end
            else if (op_reg <= OP_DIV)
            begin
                if (den_reg == '0)
                    status <= 1'b1;
                else
                begin
                    res_num <= ((num_s_reg ^ den_s_reg) && q_num_reg != '0)
                        ? (~q_num_reg + 1'b1) : q_num_reg;
                    res_den <= quo_reg[PW-2:0];
                end
            end
        end
    end

    assign sts.gcd_done   = (gx_reg == '0) && (gk_reg == '0);
    assign sts.div_done   = div_done_reg;
    assign sts.short_path = (op_reg > OP_DIV) || (den_reg == '0);

endmodule
`default_nettype wire

>>> rtl/rau_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module rau_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire                 out_ready,
    output rau_pkg::rau_cmd_t   cmd,
    input  wire rau_pkg::rau_sts_t sts
);
    import rau_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PROD, S_SUM, S_GCD, S_DIV_GO, S_DIV, S_FIN, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PROD;
                end
            end
            S_PROD:
            begin
                cmd.prod   = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_GCD;
            end
            S_GCD:
            begin
                if (sts.short_path)
                    state_next = S_FIN;
                else if (sts.gcd_done)
                    state_next = S_DIV_GO;
                else
                    cmd.gcd_step = 1'b1;
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

>>> rtl/rau_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module rau_checker #(
    parameter int DEN_W = 31
) (
    input wire clk,
    input wire rst_n,
    input wire req_valid,
    input wire req_ready,
    input wire res_valid,
    input wire res_ready,
    input wire [1:0] cmp_out,
    input wire status,
    input wire [DEN_W-1:0] res_den
);
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while busy");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid)
        else $error("result dropped");

    a_cmp_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (cmp_out != 2'b10))
        else $error("bad compare code");

    a_err_den: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && status) |-> (res_den == '0))
        else $error("error with nonzero denominator");
endmodule

bind rational_arithmetic_unit rau_checker #(
    .DEN_W (2*OPERAND_WIDTH-1)
) u_rau_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .cmp_out   (res.cmp_out),
    .status    (res.status),
    .res_den   (res.res_den)
);
`default_nettype wire
